FILE: rtl/rri_pkg.sv
// ----------------------------------------------------------------------------
// rri_pkg
// shared types and constants of the ray/ray intersection pipeline
// ----------------------------------------------------------------------------
package rri_pkg;

    localparam int POS_W      = 32;               // Q16.16 point coordinate
    localparam int TOL_W      = 21;               // parallel tolerance register
    localparam logic [TOL_W-1:0] TOL_RESET = 21'd16;
    localparam int QUO_W      = POS_W + 1;        // offset bits kept before saturation
    localparam int DIV_STEP   = 4;                // quotient bits per divider stage
    localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    localparam int LATENCY    = 3 + DIV_STAGES + 1;

    // sideband that travels with each word through the pipeline
    typedef struct packed {
        logic                    valid;
        logic                    par;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } side_t;

endpackage

FILE: rtl/rri_front.sv
// ----------------------------------------------------------------------------
// rri_front
// three stages: cross products, numerator and parallel test, offset products
// ----------------------------------------------------------------------------
module rri_front
    import rri_pkg::*;
#(
    parameter int DIR_W = 18,
    parameter int DEN_W = 2 * DIR_W + 1,
    parameter int P_W   = 2 * DIR_W + POS_W + 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [POS_W-1:0] a_pos_x,
    input  logic signed [POS_W-1:0] a_pos_y,
    input  logic signed [DIR_W-1:0] a_dir_cos,
    input  logic signed [DIR_W-1:0] a_dir_sin,
    input  logic signed [POS_W-1:0] b_pos_x,
    input  logic signed [POS_W-1:0] b_pos_y,
    input  logic signed [DIR_W-1:0] b_dir_cos,
    input  logic signed [DIR_W-1:0] b_dir_sin,
    input  logic [TOL_W-1:0]        tol,
    output side_t                   side_o,
    output logic [DEN_W-1:0]        den_o,
    output logic [P_W-1:0]          prod_x_o,
    output logic [P_W-1:0]          prod_y_o
);

    localparam int DIF_W = POS_W + 1;
    localparam int M_W   = DIF_W + DIR_W;
    localparam int N_W   = M_W + 1;
    localparam int CP_W  = 2 * DIR_W;

    // stage 1
    logic [DIR_W-1:0]        mag_ac, mag_bc;
    logic                    sel_a;
    logic signed [DIF_W-1:0] dx, dy;
    logic signed [DIR_W-1:0] ws, wc;
    side_t                   s1_side_reg, s1_side_next;
    logic signed [M_W-1:0]   m1_reg, m1_next, m2_reg, m2_next;
    logic signed [CP_W-1:0]  c1_reg, c1_next, c2_reg, c2_next;
    logic signed [DIR_W-1:0] dcx_reg, dcx_next, dcy_reg, dcy_next;

    assign mag_ac = a_dir_cos[DIR_W-1] ? (~a_dir_cos + 1'b1) : a_dir_cos;
    assign mag_bc = b_dir_cos[DIR_W-1] ? (~b_dir_cos + 1'b1) : b_dir_cos;
    assign sel_a  = (mag_ac < mag_bc);
    assign dx     = DIF_W'(a_pos_x) - DIF_W'(b_pos_x);
    assign dy     = DIF_W'(b_pos_y) - DIF_W'(a_pos_y);
    assign ws     = sel_a ? b_dir_sin : a_dir_sin;
    assign wc     = sel_a ? b_dir_cos : a_dir_cos;

    always_comb
    begin
        s1_side_next       = '0;
        s1_side_next.valid = in_valid;
        s1_side_next.pos_x = sel_a ? a_pos_x : b_pos_x;
        s1_side_next.pos_y = sel_a ? a_pos_y : b_pos_y;
        m1_next            = dx * ws;
        m2_next            = dy * wc;
        c1_next            = a_dir_cos * b_dir_sin;
        c2_next            = a_dir_sin * b_dir_cos;
        dcx_next           = sel_a ? a_dir_cos : b_dir_cos;
        dcy_next           = sel_a ? a_dir_sin : b_dir_sin;
    end

    // stage 2
    logic signed [N_W-1:0]   n_s;
    logic signed [DEN_W-1:0] c_s;
    logic [DEN_W-1:0]        mag_c;
    side_t                   s2_side_reg, s2_side_next;
    logic [N_W-1:0]          mn_reg, mn_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DIR_W-1:0]        mdx_reg, mdx_next, mdy_reg, mdy_next;

    assign n_s   = N_W'(m1_reg) + N_W'(m2_reg);
    assign c_s   = DEN_W'(c1_reg) - DEN_W'(c2_reg);
    assign mag_c = c_s[DEN_W-1] ? (~c_s + 1'b1) : c_s;

    always_comb
    begin
        s2_side_next       = s1_side_reg;
        // ray a: n over -c, ray b: -n over c, same sign either way
        s2_side_next.neg_x = ~(dcx_reg[DIR_W-1] ^ n_s[N_W-1] ^ c_s[DEN_W-1]);
        s2_side_next.neg_y = ~(dcy_reg[DIR_W-1] ^ n_s[N_W-1] ^ c_s[DEN_W-1]);
        s2_side_next.par   = ({{TOL_W{1'b0}}, mag_c} <= {{DEN_W{1'b0}}, tol});
        mn_next            = n_s[N_W-1] ? (~n_s + 1'b1) : n_s;
        den_next           = mag_c;
        mdx_next           = dcx_reg[DIR_W-1] ? (~dcx_reg + 1'b1) : dcx_reg;
        mdy_next           = dcy_reg[DIR_W-1] ? (~dcy_reg + 1'b1) : dcy_reg;
    end

    // stage 3
    side_t            s3_side_reg;
    logic [DEN_W-1:0] den3_reg;
    logic [P_W-1:0]   px_reg, px_next, py_reg, py_next;

    assign px_next = mdx_reg * mn_reg;
    assign py_next = mdy_reg * mn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
            s2_side_reg <= '0;
            s3_side_reg <= '0;
        end
        else
        begin
            s1_side_reg <= s1_side_next;
            s2_side_reg <= s2_side_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
        dcx_reg  <= dcx_next;
        dcy_reg  <= dcy_next;
        mn_reg   <= mn_next;
        den_reg  <= den_next;
        mdx_reg  <= mdx_next;
        mdy_reg  <= mdy_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        den3_reg <= den_reg;
    end

    assign side_o   = s3_side_reg;
    assign den_o    = den3_reg;
    assign prod_x_o = px_reg;
    assign prod_y_o = py_reg;

endmodule

FILE: rtl/rri_div_stage.sv
// ----------------------------------------------------------------------------
// rri_div_stage
// one stage of the restoring divider, a few quotient bits for x and y
// ----------------------------------------------------------------------------
module rri_div_stage
    import rri_pkg::*;
#(
    parameter int DEN_W = 37,
    parameter int STEPS = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  side_t            side_i,
    input  logic [DEN_W-1:0] den_i,
    input  logic             ovf_x_i,
    input  logic             ovf_y_i,
    input  logic [DEN_W-1:0] rem_x_i,
    input  logic [DEN_W-1:0] rem_y_i,
    input  logic [QUO_W-1:0] lo_x_i,
    input  logic [QUO_W-1:0] lo_y_i,
    output side_t            side_o,
    output logic [DEN_W-1:0] den_o,
    output logic             ovf_x_o,
    output logic             ovf_y_o,
    output logic [DEN_W-1:0] rem_x_o,
    output logic [DEN_W-1:0] rem_y_o,
    output logic [QUO_W-1:0] lo_x_o,
    output logic [QUO_W-1:0] lo_y_o
);

    side_t            side_reg;
    logic [DEN_W-1:0] den_reg;
    logic             ovf_x_reg, ovf_y_reg;
    logic [DEN_W-1:0] rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QUO_W-1:0] lo_x_reg, lo_x_next, lo_y_reg, lo_y_next;

    // dividend bits shift out of the top of lo, quotient bits shift in below
    always_comb
    begin
        logic [DEN_W:0] tx, ty;
        rem_x_next = rem_x_i;
        rem_y_next = rem_y_i;
        lo_x_next  = lo_x_i;
        lo_y_next  = lo_y_i;
        for (int i = 0; i < STEPS; i++)
        begin
            tx        = {rem_x_next, lo_x_next[QUO_W-1]};
            ty        = {rem_y_next, lo_y_next[QUO_W-1]};
            lo_x_next = {lo_x_next[QUO_W-2:0], 1'b0};
            lo_y_next = {lo_y_next[QUO_W-2:0], 1'b0};
            if (tx >= {1'b0, den_i})
            begin
                tx           = tx - {1'b0, den_i};
                lo_x_next[0] = 1'b1;
            end
            if (ty >= {1'b0, den_i})
            begin
                ty           = ty - {1'b0, den_i};
                lo_y_next[0] = 1'b1;
            end
            rem_x_next = tx[DEN_W-1:0];
            rem_y_next = ty[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg   <= den_i;
        ovf_x_reg <= ovf_x_i;
        ovf_y_reg <= ovf_y_i;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        lo_x_reg  <= lo_x_next;
        lo_y_reg  <= lo_y_next;
    end

    assign side_o  = side_reg;
    assign den_o   = den_reg;
    assign ovf_x_o = ovf_x_reg;
    assign ovf_y_o = ovf_y_reg;
    assign rem_x_o = rem_x_reg;
    assign rem_y_o = rem_y_reg;
    assign lo_x_o  = lo_x_reg;
    assign lo_y_o  = lo_y_reg;

endmodule

FILE: rtl/rri_out.sv
// ----------------------------------------------------------------------------
// rri_out
// adds the signed offset to the point, saturates, zero if parallel; registered
// ----------------------------------------------------------------------------
module rri_out
    import rri_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  side_t                   side_i,
    input  logic                    ovf_x_i,
    input  logic                    ovf_y_i,
    input  logic [QUO_W-1:0]        quo_x_i,
    input  logic [QUO_W-1:0]        quo_y_i,
    output logic                    done,
    output logic signed [POS_W-1:0] meet_x,
    output logic signed [POS_W-1:0] meet_y,
    output logic                    is_parallel,
    output logic                    clipped
);

    localparam int R_W = POS_W + 4;
    localparam logic signed [R_W-1:0] R_MAX = R_W'({1'b0, {(POS_W-1){1'b1}}});
    localparam logic signed [R_W-1:0] R_MIN = -R_MAX - 1;

    logic signed [R_W-1:0]   mag_x, mag_y, rx, ry;
    logic                    clip_x, clip_y;
    logic                    done_reg;
    logic signed [POS_W-1:0] mx_reg, mx_next, my_reg, my_next;
    logic                    par_reg, clip_reg, clip_next;

    // an overflowed quotient stands in as 2^QUO_W, far enough to saturate
    assign mag_x = ovf_x_i ? (R_W'(1) <<< QUO_W) : R_W'({1'b0, quo_x_i});
    assign mag_y = ovf_y_i ? (R_W'(1) <<< QUO_W) : R_W'({1'b0, quo_y_i});
    assign rx    = side_i.neg_x ? (R_W'(side_i.pos_x) - mag_x) : (R_W'(side_i.pos_x) + mag_x);
    assign ry    = side_i.neg_y ? (R_W'(side_i.pos_y) - mag_y) : (R_W'(side_i.pos_y) + mag_y);
    assign clip_x = (rx > R_MAX) || (rx < R_MIN);
    assign clip_y = (ry > R_MAX) || (ry < R_MIN);

    always_comb
    begin
        if (side_i.par)
        begin
            mx_next   = '0;
            my_next   = '0;
            clip_next = 1'b0;
        end
        else
        begin
            mx_next   = (rx > R_MAX) ? R_MAX[POS_W-1:0] :
                        (rx < R_MIN) ? R_MIN[POS_W-1:0] : rx[POS_W-1:0];
            my_next   = (ry > R_MAX) ? R_MAX[POS_W-1:0] :
                        (ry < R_MIN) ? R_MIN[POS_W-1:0] : ry[POS_W-1:0];
            clip_next = clip_x || clip_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        par_reg  <= side_i.par;
        clip_reg <= clip_next;
    end

    assign done        = done_reg;
    assign meet_x      = mx_reg;
    assign meet_y      = my_reg;
    assign is_parallel = par_reg;
    assign clipped     = clip_reg;

endmodule

FILE: rtl/ray_ray_intersection.sv
// ----------------------------------------------------------------------------
// ray_ray_intersection
// pipelined two-dimensional intersection of two rays with parallel detection
// ----------------------------------------------------------------------------
// A word (two rays) is taken whenever start is high and busy is low; busy
// stays low, so a new word may enter in every clock cycle. Each word comes
// out as a one-cycle done strobe with meet_x, meet_y, is_parallel and clipped;
// the receiver must take it then. The pipeline has three front stages
// (cross products, numerator and parallel test, offset products), nine
// restoring divider stages of four quotient bits each for x and y (the
// last one bit) and an output stage that adds the offset to the point and
// saturates. The user must write the parallel tolerance via the always
// ready cfg_valid/cfg_ready only while no word is in flight; not enforced.
// ----------------------------------------------------------------------------
module ray_ray_intersection
    import rri_pkg::*;
#(
    parameter int DIR_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [TOL_W-1:0]              cfg_data,
    input  logic signed [POS_W-1:0]       a_pos_x,
    input  logic signed [POS_W-1:0]       a_pos_y,
    input  logic signed [DIR_FRAC_BITS+1:0] a_dir_cos,
    input  logic signed [DIR_FRAC_BITS+1:0] a_dir_sin,
    input  logic signed [POS_W-1:0]       b_pos_x,
    input  logic signed [POS_W-1:0]       b_pos_y,
    input  logic signed [DIR_FRAC_BITS+1:0] b_dir_cos,
    input  logic signed [DIR_FRAC_BITS+1:0] b_dir_sin,
    output logic signed [POS_W-1:0]       meet_x,
    output logic signed [POS_W-1:0]       meet_y,
    output logic                          is_parallel,
    output logic                          clipped
);

    // direction words carry sign, one integer bit and the fraction
    localparam int DIR_W = DIR_FRAC_BITS + 2;
    // |direction cross product| fits this many bits
    localparam int DEN_W = 2 * DIR_W + 1;
    // |direction| * |numerator|, the dividend of each coordinate
    localparam int P_W   = 2 * DIR_W + POS_W + 2;

    // tolerance register, the only configuration
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    // the pipeline never stalls, so words are always welcome
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // front stages
    side_t            f_side;
    logic [DEN_W-1:0] f_den;
    logic [P_W-1:0]   f_px, f_py;

    rri_front #(
        .DIR_W (DIR_W),
        .DEN_W (DEN_W),
        .P_W   (P_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .a_pos_x   (a_pos_x),
        .a_pos_y   (a_pos_y),
        .a_dir_cos (a_dir_cos),
        .a_dir_sin (a_dir_sin),
        .b_pos_x   (b_pos_x),
        .b_pos_y   (b_pos_y),
        .b_dir_cos (b_dir_cos),
        .b_dir_sin (b_dir_sin),
        .tol       (tol_reg),
        .side_o    (f_side),
        .den_o     (f_den),
        .prod_x_o  (f_px),
        .prod_y_o  (f_py)
    );

    // divider chain; stage k reads index k and drives index k+1
    side_t            d_side [0:DIV_STAGES];
    logic [DEN_W-1:0] d_den  [0:DIV_STAGES];
    logic             d_ovfx [0:DIV_STAGES];
    logic             d_ovfy [0:DIV_STAGES];
    logic [DEN_W-1:0] d_remx [0:DIV_STAGES];
    logic [DEN_W-1:0] d_remy [0:DIV_STAGES];
    logic [QUO_W-1:0] d_lox  [0:DIV_STAGES];
    logic [QUO_W-1:0] d_loy  [0:DIV_STAGES];

    // the upper dividend bits seed the remainder; a seed at or above the
    // divisor means the offset is beyond 2^QUO_W and will saturate
    assign d_side[0] = f_side;
    assign d_den[0]  = f_den;
    assign d_remx[0] = f_px[P_W-1:QUO_W];
    assign d_remy[0] = f_py[P_W-1:QUO_W];
    assign d_ovfx[0] = (f_px[P_W-1:QUO_W] >= f_den);
    assign d_ovfy[0] = (f_py[P_W-1:QUO_W] >= f_den);
    assign d_lox[0]  = f_px[QUO_W-1:0];
    assign d_loy[0]  = f_py[QUO_W-1:0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        // last stage takes whatever quotient bits are left
        localparam int LEFT  = QUO_W - k * DIV_STEP;
        localparam int STEPS = (LEFT < DIV_STEP) ? LEFT : DIV_STEP;

        rri_div_stage #(
            .DEN_W (DEN_W),
            .STEPS (STEPS)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .side_i  (d_side[k]),
            .den_i   (d_den[k]),
            .ovf_x_i (d_ovfx[k]),
            .ovf_y_i (d_ovfy[k]),
            .rem_x_i (d_remx[k]),
            .rem_y_i (d_remy[k]),
            .lo_x_i  (d_lox[k]),
            .lo_y_i  (d_loy[k]),
            .side_o  (d_side[k+1]),
            .den_o   (d_den[k+1]),
            .ovf_x_o (d_ovfx[k+1]),
            .ovf_y_o (d_ovfy[k+1]),
            .rem_x_o (d_remx[k+1]),
            .rem_y_o (d_remy[k+1]),
            .lo_x_o  (d_lox[k+1]),
            .lo_y_o  (d_loy[k+1])
        );
    end

    // offset, saturation and result register
    rri_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .side_i      (d_side[DIV_STAGES]),
        .ovf_x_i     (d_ovfx[DIV_STAGES]),
        .ovf_y_i     (d_ovfy[DIV_STAGES]),
        .quo_x_i     (d_lox[DIV_STAGES]),
        .quo_y_i     (d_loy[DIV_STAGES]),
        .done        (done),
        .meet_x      (meet_x),
        .meet_y      (meet_y),
        .is_parallel (is_parallel),
        .clipped     (clipped)
    );

endmodule

FILE: rtl/rri_checker.sv
// ----------------------------------------------------------------------------
// rri_checker
// port-level checks of the intersection pipeline, bound to the top level
// ----------------------------------------------------------------------------
module rri_checker
    import rri_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic signed [POS_W-1:0] meet_x,
    input logic signed [POS_W-1:0] meet_y,
    input logic                    is_parallel,
    input logic                    clipped
);

    localparam logic signed [POS_W-1:0] SAT_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] SAT_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not come out on time");

    // no result without a word taken the same latency earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result without accepted word");

    // parallel rays give a zero point and no clipping
    a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_parallel) |-> (meet_x == '0 && meet_y == '0 && !clipped))
        else $error("parallel result not zero");

    // clipping shows up as a coordinate at a range limit
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |-> (meet_x == SAT_MAX || meet_x == SAT_MIN ||
                               meet_y == SAT_MAX || meet_y == SAT_MIN))
        else $error("clipped set without saturated coordinate");

endmodule

bind ray_ray_intersection rri_checker u_rri_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .meet_x      (meet_x),
    .meet_y      (meet_y),
    .is_parallel (is_parallel),
    .clipped     (clipped)
);
